### design/dtcr_pkg.sv
// shared types, constants and code table of the dial tap-code recognizer
package dtcr_pkg;

    localparam int CODE_LENGTH = 3;
    localparam int NUM_CODES   = 7;
    localparam int CNT_W       = $clog2(CODE_LENGTH + 1);
    localparam int FRAC_BITS   = 20;

    // tan(15 deg) in unsigned q0.20 (value below 0.5, top fraction bit dropped)
    localparam logic [18:0] TAN15_Q20 = 19'd280965;

    typedef logic [3:0]       hour_t;
    typedef logic [CNT_W-1:0] count_t;

    localparam hour_t  HOUR_NONE   = 4'd0;
    localparam hour_t  HOUR_CENTER = 4'd3;
    localparam hour_t  HOUR_HALF   = 4'd6;
    localparam hour_t  HOUR_TOP    = 4'd12;
    localparam count_t FULL_COUNT  = count_t'(CODE_LENGTH);

    typedef enum logic [2:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_RING_RADIUS  = 3'd2,
        REG_HIT_MARGIN   = 3'd3,
        REG_TAP_GAP      = 3'd4,
        REG_TOTAL_WINDOW = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [9:0]  center_x;
        logic [9:0]  center_y;
        logic [8:0]  ring_radius;
        logic [7:0]  hit_margin;
        logic [15:0] tap_gap_ms;
        logic [15:0] total_window_ms;
    } dtcr_cfg_t;

    // classified tap handed from the front end to the sequencer
    typedef struct packed {
        hour_t       hour;
        logic [31:0] tap_ms;
    } dtcr_item_t;

    typedef struct packed {
        hour_t      dial_hour;
        logic       code_matched;
        logic [2:0] code_index;
        count_t     taps_held;
    } dtcr_result_t;

    localparam hour_t CODE_TABLE [NUM_CODES][CODE_LENGTH] = '{
        '{4'd1,  4'd2,  4'd3},
        '{4'd4,  4'd4,  4'd3},
        '{4'd1,  4'd7,  4'd5},
        '{4'd1,  4'd4,  4'd5},
        '{4'd2,  4'd9,  4'd5},
        '{4'd9,  4'd8,  4'd7},
        '{4'd12, 4'd11, 4'd10}
    };

endpackage

### design/dtcr_front.sv
// front end: two-stage ring test and hour-sector classification of a touch
module dtcr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  dtcr_pkg::dtcr_cfg_t cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [9:0]          touch_x,
    input  logic [9:0]          touch_y,
    input  logic [31:0]         time_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output dtcr_pkg::dtcr_item_t out_item
);
    import dtcr_pkg::*;

    // stage 1: offsets, magnitudes, ring bounds
    logic [10:0] dx;
    logic [10:0] dy;
    logic [10:0] dx_abs;
    logic [10:0] dy_abs;
    logic [8:0]  rmin;
    logic [9:0]  rmax;

    logic        s1_valid_reg;
    logic [9:0]  s1_a_reg;
    logic [9:0]  s1_b_reg;
    logic        s1_dx_neg_reg;
    logic        s1_dx_zero_reg;
    logic        s1_dy_neg_reg;
    logic        s1_dy_zero_reg;
    logic [8:0]  s1_rmin_reg;
    logic [9:0]  s1_rmax_reg;
    logic [31:0] s1_ms_reg;

    // stage 2: registered products
    logic        s2_valid_reg;
    logic [19:0] s2_aa_reg;
    logic [19:0] s2_bb_reg;
    logic [28:0] s2_ak_reg;
    logic [28:0] s2_bk_reg;
    logic [17:0] s2_rmin2_reg;
    logic [19:0] s2_rmax2_reg;
    logic [9:0]  s2_a_reg;
    logic [9:0]  s2_b_reg;
    logic        s2_dx_neg_reg;
    logic        s2_dx_zero_reg;
    logic        s2_dy_neg_reg;
    logic        s2_dy_zero_reg;
    logic [31:0] s2_ms_reg;

    logic        s1_ready;
    logic        s2_ready;
    logic        s1_take;
    logic        s2_take;

    logic [20:0] d2;
    logic        miss;
    logic [29:0] a_shift;
    logic [29:0] b_shift;
    hour_t       off;
    hour_t       hour_raw;
    hour_t       hour;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign s1_take  = in_valid && s1_ready;
    assign s2_take  = s1_valid_reg && s2_ready;

    always_comb
    begin
        dx     = {1'b0, touch_x} - {1'b0, cfg.center_x};
        dy     = {1'b0, touch_y} - {1'b0, cfg.center_y};
        dx_abs = dx[10] ? (11'd0 - dx) : dx;
        dy_abs = dy[10] ? (11'd0 - dy) : dy;
        rmin   = (cfg.ring_radius > {1'b0, cfg.hit_margin})
               ? (cfg.ring_radius - {1'b0, cfg.hit_margin}) : 9'd0;
        rmax   = {1'b0, cfg.ring_radius} + {2'b00, cfg.hit_margin};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            s1_a_reg       <= dx_abs[9:0];
            s1_b_reg       <= dy_abs[9:0];
            s1_dx_neg_reg  <= dx[10];
            s1_dx_zero_reg <= (dx == 11'd0);
            s1_dy_neg_reg  <= dy[10];
            s1_dy_zero_reg <= (dy == 11'd0);
            s1_rmin_reg    <= rmin;
            s1_rmax_reg    <= rmax;
            s1_ms_reg      <= time_ms;
        end
        if (s2_take)
        begin
            s2_aa_reg      <= s1_a_reg * s1_a_reg;
            s2_bb_reg      <= s1_b_reg * s1_b_reg;
            s2_ak_reg      <= {19'd0, s1_a_reg} * {10'd0, TAN15_Q20};
            s2_bk_reg      <= {19'd0, s1_b_reg} * {10'd0, TAN15_Q20};
            s2_rmin2_reg   <= s1_rmin_reg * s1_rmin_reg;
            s2_rmax2_reg   <= s1_rmax_reg * s1_rmax_reg;
            s2_a_reg       <= s1_a_reg;
            s2_b_reg       <= s1_b_reg;
            s2_dx_neg_reg  <= s1_dx_neg_reg;
            s2_dx_zero_reg <= s1_dx_zero_reg;
            s2_dy_neg_reg  <= s1_dy_neg_reg;
            s2_dy_zero_reg <= s1_dy_zero_reg;
            s2_ms_reg      <= s1_ms_reg;
        end
    end

    // ring test, sector offset from the vertical axis, then quadrant fold
    always_comb
    begin
        d2      = {1'b0, s2_aa_reg} + {1'b0, s2_bb_reg};
        miss    = (d2 < {3'b000, s2_rmin2_reg}) || (d2 > {1'b0, s2_rmax2_reg});
        a_shift = {s2_a_reg, {FRAC_BITS{1'b0}}};
        b_shift = {s2_b_reg, {FRAC_BITS{1'b0}}};

        if (a_shift < {1'b0, s2_bk_reg})
        begin
            off = 4'd0;
        end
        else if (s2_a_reg < s2_b_reg)
        begin
            off = 4'd1;
        end
        else if (b_shift < {1'b0, s2_ak_reg})
        begin
            off = 4'd3;
        end
        else
        begin
            off = 4'd2;
        end

        if (s2_dy_neg_reg && !s2_dx_neg_reg)
        begin
            hour_raw = off;
        end
        else if (!s2_dx_neg_reg && !s2_dx_zero_reg && !s2_dy_neg_reg)
        begin
            hour_raw = HOUR_HALF - off;
        end
        else if (!s2_dy_neg_reg && !s2_dy_zero_reg && (s2_dx_neg_reg || s2_dx_zero_reg))
        begin
            hour_raw = HOUR_HALF + off;
        end
        else
        begin
            hour_raw = HOUR_TOP - off;
        end

        if (miss)
        begin
            hour = HOUR_NONE;
        end
        else if (s2_dx_zero_reg && s2_dy_zero_reg)
        begin
            hour = HOUR_CENTER;
        end
        else if (hour_raw == HOUR_NONE)
        begin
            hour = HOUR_TOP;
        end
        else
        begin
            hour = hour_raw;
        end
    end

    assign out_valid       = s2_valid_reg;
    assign out_item.hour   = hour;
    assign out_item.tap_ms = s2_ms_reg;

endmodule

### design/dtcr_fifo.sv
// two-entry queue of classified taps between front end and sequencer
module dtcr_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dtcr_pkg::dtcr_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dtcr_pkg::dtcr_item_t out_item
);
    import dtcr_pkg::*;

    dtcr_item_t  mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef ASSERT_OFF
    // fill level never goes past the two entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue fill level out of range");

    // pointers stay apart by the fill level
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)))
        else $error("queue pointers disagree with fill level");
`endif

endmodule

### design/dtcr_back.sv
// sequencer: timeout handling, sliding tap window and code match
module dtcr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dtcr_pkg::dtcr_cfg_t    cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dtcr_pkg::dtcr_item_t   in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dtcr_pkg::dtcr_result_t out_result
);
    import dtcr_pkg::*;

    hour_t        hours_reg  [CODE_LENGTH];
    hour_t        hours_next [CODE_LENGTH];
    count_t       count_reg;
    count_t       count_next;
    logic [31:0]  first_reg;
    logic [31:0]  first_next;
    logic [31:0]  last_reg;
    logic [31:0]  last_next;
    logic         out_valid_reg;
    dtcr_result_t result_reg;
    dtcr_result_t result_next;

    logic         take;
    logic [31:0]  gap;
    logic [31:0]  span;
    logic         expired;
    count_t       cnt_base;
    logic         matched;
    logic [2:0]   idx;

    assign in_ready   = !out_valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        hours_next = hours_reg;
        count_next = count_reg;
        first_next = first_reg;
        last_next  = last_reg;
        matched    = 1'b0;
        idx        = 3'd0;
        gap        = in_item.tap_ms - last_reg;
        span       = in_item.tap_ms - first_reg;
        expired    = (count_reg != '0) &&
                     ((gap > {16'd0, cfg.tap_gap_ms}) ||
                      (span > {16'd0, cfg.total_window_ms}));
        cnt_base   = expired ? '0 : count_reg;

        if (in_item.hour == HOUR_NONE)
        begin
            count_next = '0;
            first_next = 32'd0;
            last_next  = 32'd0;
        end
        else
        begin
            first_next = (cnt_base == '0) ? in_item.tap_ms : first_reg;
            if (cnt_base < FULL_COUNT)
            begin
                hours_next[cnt_base] = in_item.hour;
                count_next           = cnt_base + count_t'(1);
            end
            else
            begin
                for (int i = 0; i < CODE_LENGTH - 1; i++)
                begin
                    hours_next[i] = hours_reg[i + 1];
                end
                hours_next[CODE_LENGTH - 1] = in_item.hour;
            end
            last_next = in_item.tap_ms;

            if (count_next == FULL_COUNT)
            begin
                // first matching code in table order wins
                for (int k = 0; k < NUM_CODES; k++)
                begin
                    if (!matched &&
                        hours_next[0] == CODE_TABLE[k][0] &&
                        hours_next[1] == CODE_TABLE[k][1] &&
                        hours_next[2] == CODE_TABLE[k][2])
                    begin
                        matched = 1'b1;
                        idx     = 3'(k);
                    end
                end
                if (matched)
                begin
                    count_next = '0;
                    first_next = 32'd0;
                    last_next  = 32'd0;
                end
            end
        end

        result_next.dial_hour    = in_item.hour;
        result_next.code_matched = matched;
        result_next.code_index   = idx;
        result_next.taps_held    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                hours_reg[i] <= HOUR_NONE;
            end
            count_reg     <= '0;
            first_reg     <= 32'd0;
            last_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                hours_reg <= hours_next;
                count_reg <= count_next;
                first_reg <= first_next;
                last_reg  <= last_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

`ifndef ASSERT_OFF
    // a waiting result reports the tap count the sequence holds now
    a_taps_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.taps_held == count_reg))
        else $error("reported tap count differs from sequence state");

    // a match comes from an on-ring tap and empties the sequence
    a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.code_matched) |->
        (result_reg.taps_held == '0 && result_reg.dial_hour != HOUR_NONE))
        else $error("match without cleared sequence");

    // a miss reports nothing held and no match
    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.dial_hour == HOUR_NONE) |->
        (result_reg.taps_held == '0 && !result_reg.code_matched &&
         result_reg.code_index == 3'd0))
        else $error("miss left taps or a match");
`endif

endmodule

### design/dial_tap_code_recognizer_top.sv
// top level of the dial tap-code recognizer: config registers and block wiring
//
// Each touch transfer (x, y, millisecond time) yields exactly one result
// transfer: the dial hour 1..12 (12 at top, clockwise, y growing downward) or
// 0 off the ring, a code-match flag with the code index, and the number of
// taps held. The block takes one touch per clock cycle sustained while the
// result side does not stall. A touch passes two front-end stages (offsets and
// magnitudes, then squares and the tan(15 deg) products), is classified into an
// hour as it enters a two-entry queue, and the sequencer updates the tap window
// and loads the output register the cycle it pops the queue. The queue and the
// output register let either side stall alone; s_tready drops only when the
// front stages and the queue are all full. Timeouts compare modulo-2^32 time
// differences with the gap and window limits. Configuration registers are
// written through cfg_wr_en/cfg_index/cfg_wdata and should only change while no
// touch is in flight; an index past the last register is ignored.
module dial_tap_code_recognizer_top (
    input  logic        clk,
    input  logic        rst_n,

    // touch stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // touch_x[9:0], touch_y[19:10], time_ms[51:20], zero pad

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // dial_hour[3:0], code_matched[4], code_index[7:5],
                                   // taps_held[9:8], zero pad

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import dtcr_pkg::*;

    dtcr_cfg_t    cfg_reg;
    dtcr_item_t   front_item;
    logic         front_valid;
    logic         front_ready;
    dtcr_item_t   queue_item;
    logic         queue_valid;
    logic         queue_ready;
    dtcr_result_t result;

    // configuration registers, reset to the default dial geometry and timing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x        <= 10'd233;
            cfg_reg.center_y        <= 10'd238;
            cfg_reg.ring_radius     <= 9'd168;
            cfg_reg.hit_margin      <= 8'd42;
            cfg_reg.tap_gap_ms      <= 16'd1500;
            cfg_reg.total_window_ms <= 16'd4500;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTER_X:     cfg_reg.center_x        <= cfg_wdata[9:0];
                REG_CENTER_Y:     cfg_reg.center_y        <= cfg_wdata[9:0];
                REG_RING_RADIUS:  cfg_reg.ring_radius     <= cfg_wdata[8:0];
                REG_HIT_MARGIN:   cfg_reg.hit_margin      <= cfg_wdata[7:0];
                REG_TAP_GAP:      cfg_reg.tap_gap_ms      <= cfg_wdata;
                REG_TOTAL_WINDOW: cfg_reg.total_window_ms <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // front end: ring test and sector classification
    dtcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .touch_x   (s_tdata[9:0]),
        .touch_y   (s_tdata[19:10]),
        .time_ms   (s_tdata[51:20]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    // decoupling queue of classified taps
    dtcr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    // sequencer with the output register
    dtcr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_item    (queue_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // pack the result, lowest field first
    assign m_tdata = {6'd0, result.taps_held, result.code_index,
                      result.code_matched, result.dial_hour};

endmodule

### test/testbench.sv
// testbench of the dial tap-code recognizer: directed and random touch streams checked per result
`timescale 1ns / 100ps

module testbench;

    import dtcr_pkg::*;

    // run length and pacing
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_TOUCHES = 240;
    localparam int SETTLE_CYCLES = 8;

    // register indexes past the end of the list, the block must ignore them
    localparam logic [2:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [2:0] SPARE_INDEX_HI = 3'd7;

    // tan(15 deg) scaled by 2^20, used by the sector split
    localparam longint TAN15_FRAC = 280965;
    localparam real    DEG_TO_RAD = 3.14159265358979 / 180.0;

    // stored three-tap codes in priority order
    localparam int NUM_KNOWN = 7;
    localparam int KNOWN_CODES [NUM_KNOWN][3] = '{
        '{1, 2, 3}, '{4, 4, 3}, '{1, 7, 5}, '{1, 4, 5},
        '{2, 9, 5}, '{9, 8, 7}, '{12, 11, 10}
    };

    // predicts one result per touch transfer and checks result transfers in order
    class tap_code_board;
        logic [9:0]  cx, cy;
        logic [8:0]  radius;
        logic [7:0]  margin;
        logic [15:0] gap_ms, window_ms;

        hour_t        held_hours [3];
        int           held;
        logic [31:0]  first_ms, last_ms;
        dtcr_result_t pending_results [$];
        int           errors;

        function new();
            cx        = 10'd233;
            cy        = 10'd238;
            radius    = 9'd168;
            margin    = 8'd42;
            gap_ms    = 16'd1500;
            window_ms = 16'd4500;
            for (int i = 0; i < 3; i++)
                held_hours[i] = '0;
            drop_sequence();
            errors = 0;
        endfunction

        function void drop_sequence();
            held     = 0;
            first_ms = '0;
            last_ms  = '0;
        endfunction

        function void apply_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_CENTER_X:     cx        = val[9:0];
                REG_CENTER_Y:     cy        = val[9:0];
                REG_RING_RADIUS:  radius    = val[8:0];
                REG_HIT_MARGIN:   margin    = val[7:0];
                REG_TAP_GAP:      gap_ms    = val;
                REG_TOTAL_WINDOW: window_ms = val;
                default: ;
            endcase
        endfunction

        function hour_t hour_at(logic [9:0] x, logic [9:0] y);
            int     dx, dy, off, h;
            longint a, b, d2, inner, outer;
            dx    = int'(x) - int'(cx);
            dy    = int'(y) - int'(cy);
            a     = (dx < 0) ? -dx : dx;
            b     = (dy < 0) ? -dy : dy;
            d2    = a * a + b * b;
            inner = (radius > margin) ? longint'(radius) - longint'(margin) : 0;
            outer = longint'(radius) + longint'(margin);
            if (d2 < inner * inner || d2 > outer * outer)
                return hour_t'(0);
            if (dx == 0 && dy == 0)
                return hour_t'(3);
            // 30 degree sectors from the vertical, compared without angles
            if ((a << 20) < b * TAN15_FRAC)
                off = 0;
            else if (a < b)
                off = 1;
            else if ((b << 20) < a * TAN15_FRAC)
                off = 3;
            else
                off = 2;
            // screen y grows downward
            if (dy < 0 && dx >= 0)
                h = off;
            else if (dx > 0 && dy >= 0)
                h = 6 - off;
            else if (dy > 0 && dx <= 0)
                h = 6 + off;
            else
                h = 12 - off;
            if (h == 0)
                h = 12;
            return hour_t'(h);
        endfunction

        function void note_touch(logic [9:0] x, logic [9:0] y, logic [31:0] t);
            hour_t        h;
            logic [31:0]  since_last, since_first;
            dtcr_result_t r;
            h              = hour_at(x, y);
            r.dial_hour    = h;
            r.code_matched = 1'b0;
            r.code_index   = '0;
            if (h == 0)
                drop_sequence();
            else
            begin
                since_last  = t - last_ms;
                since_first = t - first_ms;
                if (held > 0 && (since_last > gap_ms || since_first > window_ms))
                    drop_sequence();
                if (held == 0)
                    first_ms = t;
                if (held < 3)
                begin
                    held_hours[held] = h;
                    held++;
                end
                else
                begin
                    held_hours[0] = held_hours[1];
                    held_hours[1] = held_hours[2];
                    held_hours[2] = h;
                end
                last_ms = t;
                if (held >= 3)
                begin
                    for (int k = 0; k < NUM_KNOWN && !r.code_matched; k++)
                        if (held_hours[0] == KNOWN_CODES[k][0] &&
                            held_hours[1] == KNOWN_CODES[k][1] &&
                            held_hours[2] == KNOWN_CODES[k][2])
                        begin
                            r.code_matched = 1'b1;
                            r.code_index   = 3'(k);
                        end
                    if (r.code_matched)
                        drop_sequence();
                end
            end
            r.taps_held = count_t'(held);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [15:0] word);
            dtcr_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with no touch pending, got %h", $time, word);
                return;
            end
            want = pending_results.pop_front();
            if (word[3:0] !== want.dial_hour || word[4] !== want.code_matched ||
                word[7:5] !== want.code_index || word[9:8] !== want.taps_held)
            begin
                errors++;
                $display("%0t: expected hour %0d match %0d index %0d held %0d, %s",
                         $time, want.dial_hour, want.code_matched, want.code_index,
                         want.taps_held, "actual below");
                $display("%0t: actual   hour %0d match %0d index %0d held %0d",
                         $time, word[3:0], word[4], word[7:5], word[9:8]);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    // clock, reset and block ports
    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // touch_x[9:0], touch_y[19:10], time_ms[51:20], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // dial_hour[3:0], code_matched[4], code_index[7:5],
                            // taps_held[9:8], zero pad
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    tap_code_board board;

    // millisecond clock of the touch stream and the no-idle stretch counters
    logic [31:0] clock_ms;
    int          send_calm = 0;
    int          take_calm = 0;

    always #6 clk = ~clk;

    dial_tap_code_recognizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // idle cycles before the next transfer: mostly drawn at random, now and then a stretch with none
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [9:0] clamp_coord(int v);
        if (v < 0)
            return 10'd0;
        if (v > 1023)
            return 10'd1023;
        return v[9:0];
    endfunction

    // point near the middle of an hour sector on the ring, optionally jittered in angle
    // and radius so that it stays inside the sector and the annulus most of the time
    function automatic void ring_point(int h, bit jitter,
                                       output logic [9:0] x, output logic [9:0] y);
        real ang, rad;
        int  spread_deg, slack;
        spread_deg = jitter ? int'($urandom_range(0, 24)) - 12 : 0;
        slack      = jitter ? int'($urandom_range(0, 2 * board.margin)) - int'(board.margin) : 0;
        ang        = (30.0 * h + spread_deg) * DEG_TO_RAD;
        rad        = real'(int'(board.radius) + slack);
        x          = clamp_coord(int'(board.cx) + int'(rad * $sin(ang)));
        y          = clamp_coord(int'(board.cy) - int'(rad * $cos(ang)));
    endfunction

    // tap time: mostly within the gap limit, sometimes late, sometimes anywhere
    function automatic logic [31:0] next_tap_ms();
        int          pick;
        logic [31:0] advance;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            advance = $urandom_range(0, board.gap_ms);
        else if (pick < 80)
            advance = '0;
        else if (pick < 95)
            advance = 32'(board.gap_ms) + $urandom_range(1, 3000);
        else
            advance = $urandom;
        clock_ms += advance;
        return clock_ms;
    endfunction

    // one touch transfer; valid stays high across back-to-back transfers
    task automatic send_touch(logic [9:0] x, logic [9:0] y, logic [31:0] t);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, t, y, x};
        do @(posedge clk); while (s_tready !== 1'b1);
        board.note_touch(x, y, t);
    endtask

    task automatic tap_hour(int h, logic [31:0] t);
        logic [9:0] x, y;
        ring_point(h, 1'b0, x, y);
        send_touch(x, y, t);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.apply_reg(idx, val);
    endtask

    // random junk above a register's width, which the block has to mask off
    function automatic logic [15:0] with_junk(int val, int width);
        logic [15:0] v;
        v = 16'(val);
        if ($urandom_range(0, 1) == 1)
            v |= 16'($urandom) << width;
        return v;
    endfunction

    // full register load, only while nothing is in flight
    task automatic load_dial(int ccx, int ccy, int rad, int mar, int gap, int win);
        write_reg(REG_CENTER_X, with_junk(ccx, 10));
        write_reg(REG_CENTER_Y, with_junk(ccy, 10));
        write_reg(REG_RING_RADIUS, with_junk(rad, 9));
        write_reg(REG_HIT_MARGIN, with_junk(mar, 8));
        write_reg(REG_TAP_GAP, 16'(gap));
        write_reg(REG_TOTAL_WINDOW, 16'(win));
        write_reg(SPARE_INDEX_LO, 16'($urandom));
        write_reg(SPARE_INDEX_HI, 16'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending, wait for every expected result, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic directed_touches();
        logic [31:0] t;
        int          picks [4];
        picks = '{0, 6, 1, 5};
        // four stored codes back to back, the first one across the wrap of the ms counter
        t = 32'hFFFF_FF38;
        for (int k = 0; k < 4; k++)
            for (int i = 0; i < 3; i++)
            begin
                tap_hour(KNOWN_CODES[picks[k]][i], t);
                t += 100;
            end
        // gap over the limit restarts, so the code is lost
        tap_hour(1, t);
        t += 1600;
        tap_hour(7, t);
        t += 100;
        tap_hour(5, t);
        t += 100;
        // miss at the origin corner clears the sequence
        send_touch(10'd0, 10'd0, t);
        // total window runs out while the sequence slides
        for (int i = 0; i < 5; i++)
        begin
            tap_hour(6, t);
            t += 1400;
        end
        // miss at the far corner
        send_touch(10'd1023, 10'd1023, t);
        t += 100;
        // diagonal tie on the ring, lower right
        send_touch(clamp_coord(int'(board.cx) + 119), clamp_coord(int'(board.cy) + 119), t);
        settle();
        // margin above the radius: inner bound saturates and the exact center is hour 3
        load_dial(233, 238, 5, 200, 1500, 4500);
        send_touch(board.cx, board.cy, t);
        send_touch(clamp_coord(int'(board.cx) + 3), clamp_coord(int'(board.cy) - 3), t + 1);
        settle();
    endtask

    // mostly well-formed three-tap sequences on the ring, mixed with noise that breaks them
    task automatic random_touches(int count);
        logic [9:0] x, y;
        int         pick, k, d;
        int         plan [3];
        int         plan_pos;
        clock_ms = $urandom;
        plan_pos = 0;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                if (plan_pos == 0)
                begin
                    k = $urandom_range(0, NUM_KNOWN - 1);
                    for (int i = 0; i < 3; i++)
                        plan[i] = ($urandom_range(0, 3) != 0) ? KNOWN_CODES[k][i]
                                                              : $urandom_range(1, 12);
                end
                ring_point(plan[plan_pos], 1'b1, x, y);
                plan_pos = (plan_pos + 1) % 3;
            end
            else if (pick < 80)
            begin
                x = 10'($urandom);
                y = 10'($urandom);
            end
            else if (pick < 86)
                ring_point($urandom_range(1, 12), 1'b1, x, y);
            else if (pick < 90)
            begin
                // equal offsets on both axes
                d = int'(0.7071 * board.radius) + int'($urandom_range(0, 4)) - 2;
                x = clamp_coord(int'(board.cx) + ($urandom_range(0, 1) ? d : -d));
                y = clamp_coord(int'(board.cy) + ($urandom_range(0, 1) ? d : -d));
            end
            else if (pick < 95)
            begin
                x = clamp_coord(int'(board.cx) + int'($urandom_range(0, 4)) - 2);
                y = clamp_coord(int'(board.cy) + int'($urandom_range(0, 4)) - 2);
            end
            else
            begin
                x = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                y = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            end
            send_touch(x, y, next_tap_ms());
        end
    endtask

    // result side: random stalls on tready, one check per accepted result transfer
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(take_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            board.check_result(m_tdata);
        end
    end

    // hang guard
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        board     = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, then explicit settings including the extremes
        directed_touches();
        load_dial(233, 238, 168, 42, 1500, 4500);
        random_touches(PHASE_TOUCHES);
        settle();
        load_dial(512, 512, 300, 60, 800, 2000);
        random_touches(PHASE_TOUCHES);
        settle();
        load_dial(0, 0, 511, 255, 65535, 65535);
        random_touches(PHASE_TOUCHES);
        settle();
        load_dial(1023, 1023, 0, 0, 0, 0);
        random_touches(PHASE_TOUCHES);
        settle();
        load_dial(1023, 0, 100, 255, 200, 300);
        random_touches(PHASE_TOUCHES);
        settle();
        load_dial(0, 1023, 400, 20, 1500, 4500);
        random_touches(PHASE_TOUCHES);
        settle();
        load_dial($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 511),
                  $urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 65535));
        random_touches(PHASE_TOUCHES);
        settle();

        if (board.errors == 0 && board.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
